// ----- design/websocket_frame_deframer_core_assert.svh -----
// assertion macros used by the deframer front module
// each expects clk and rst_n in scope
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wsd_pkg.sv -----
package wsd_pkg;

  localparam int BYTE_W          = 8;
  localparam int TYPE_W          = 3;
  localparam int OPCODE_W        = 4;
  localparam int LEN_W           = 64;
  localparam int HDR_CNT_W       = 4;
  localparam int KEY_BYTES       = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  // 7-bit length escape codes
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // extended length and mask key byte counts
  localparam logic [HDR_CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [HDR_CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [HDR_CNT_W-1:0] KEY_BYTES_C = 4'd4;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
  localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
  localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
  localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;
  localparam logic [OPCODE_W-1:0] OP_PONG   = 4'hA;

  typedef enum logic [TYPE_W-1:0] {
    FT_TEXT   = 3'd0,
    FT_BINARY = 3'd1,
    FT_PING   = 3'd2,
    FT_PONG   = 3'd3,
    FT_CLOSE  = 3'd4,
    FT_OTHER  = 3'd5
  } frame_type_t;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASKKEY = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // one result word as it travels from parser to output stage
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] key;
    logic              mask_en;
    frame_type_t       ftype;
    logic              has_byte;
    logic              last;
  } q_item_t;

  function automatic frame_type_t type_code(input logic [OPCODE_W-1:0] op);
    frame_type_t ft;
    unique case (op)
      OP_TEXT:   ft = FT_TEXT;
      OP_BINARY: ft = FT_BINARY;
      OP_PING:   ft = FT_PING;
      OP_PONG:   ft = FT_PONG;
      OP_CLOSE:  ft = FT_CLOSE;
      default:   ft = FT_OTHER;
    endcase
    return ft;
  endfunction

endpackage

// ----- design/wsd_ifs.sv -----
interface wsd_in_if;
  logic                       valid;
  logic                       ready;
  logic [wsd_pkg::BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [wsd_pkg::BYTE_W-1:0] payload_byte;
  logic [wsd_pkg::TYPE_W-1:0] frame_type;
  logic                       has_byte;
  logic                       last_of_frame;

  modport source (output valid, output payload_byte, output frame_type,
                  output has_byte, output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_type,
                  input has_byte, input last_of_frame, output ready);
endinterface

// ----- design/wsd_front.sv -----
`include "websocket_frame_deframer_core_assert.svh"

module wsd_front (
  input  logic              clk,
  input  logic              rst_n,
  wsd_in_if.sink            in_ch,
  input  logic              push_full,
  output logic              push_valid,
  output wsd_pkg::q_item_t  push_item
);
  import wsd_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [OPCODE_W-1:0]   opcode_r, opcode_nxt;
  logic                  mask_r, mask_nxt;
  logic [HDR_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic [KEY_IDX_W-1:0]  mpos_r, mpos_nxt;
  logic [BYTE_W-1:0]     key_r [KEY_BYTES];

  logic                  accept;
  logic [BYTE_W-1:0]     b;
  logic                  len_done;
  logic                  hdr_done;
  logic [LEN_W-1:0]      rem_dec;

  assign in_ch.ready = !push_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.stream_byte;
  assign rem_dec     = (rem_r != '0) ? rem_r - LEN_W'(1) : rem_r;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    mpos_nxt   = mpos_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    push_valid = 1'b0;
    push_item.data     = '0;
    push_item.key      = key_r[mpos_r];
    push_item.mask_en  = 1'b0;
    push_item.ftype    = type_code(opcode_r);
    push_item.has_byte = 1'b0;
    push_item.last     = 1'b1;
    if (accept) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_nxt = b[7];
          rem_nxt  = '0;
          if (b[6:0] == LEN16_CODE) begin
            cnt_nxt   = EXT16_BYTES;
            phase_nxt = PH_EXTLEN;
          end else if (b[6:0] == LEN64_CODE) begin
            cnt_nxt   = EXT64_BYTES;
            phase_nxt = PH_EXTLEN;
          end else begin
            rem_nxt  = LEN_W'(b[6:0]);
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          rem_nxt = {rem_r[LEN_W-BYTE_W-1:0], b};
          cnt_nxt = cnt_r - HDR_CNT_W'(1);
          if (cnt_nxt == '0) begin
            len_done = 1'b1;
          end
        end
        PH_MASKKEY: begin
          cnt_nxt = cnt_r + HDR_CNT_W'(1);
          if (cnt_nxt >= KEY_BYTES_C) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt            = rem_dec;
          mpos_nxt           = mpos_r + KEY_IDX_W'(1);
          push_valid         = 1'b1;
          push_item.data     = b;
          push_item.mask_en  = mask_r;
          push_item.has_byte = 1'b1;
          push_item.last     = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          opcode_nxt = b[OPCODE_W-1:0];
          phase_nxt  = PH_HDR1;
        end
      endcase

      // length known: mask key next, or header finished
      if (len_done) begin
        if (mask_nxt) begin
          phase_nxt = PH_MASKKEY;
          cnt_nxt   = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // header finished: payload, or notice of an empty frame
      if (hdr_done) begin
        mpos_nxt = '0;
        cnt_nxt  = '0;
        if (rem_nxt == '0) begin
          phase_nxt  = PH_HDR0;
          push_valid = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      cnt_r    <= '0;
      rem_r    <= '0;
      mpos_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      mpos_r   <= mpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_MASKKEY)) begin
      key_r[cnt_r[KEY_IDX_W-1:0]] <= b;
    end
  end

  `WSD_ASSERT_IMP(a_empty_is_last, push_valid && !push_item.has_byte, push_item.last, "empty notice without last")
  `WSD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= EXT64_BYTES, "header count out of range")
  `WSD_ASSERT_NXT(a_last_to_hdr0, push_valid && push_item.last, phase_r == PH_HDR0, "frame end did not return to header")
  `WSD_ASSERT_IMP(a_no_push_full, push_valid, !push_full, "push into full queue")

endmodule

// ----- design/wsd_queue.sv -----
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  wsd_pkg::q_item_t  push_item,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output wsd_pkg::q_item_t  pop_item
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/wsd_back.sv -----
module wsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wsd_pkg::q_item_t  q_item,
  output logic              q_pop,
  wsd_out_if.source         out_ch
);
  import wsd_pkg::*;

  logic               valid_r, valid_nxt;
  logic [BYTE_W-1:0]  data_r;
  frame_type_t        ftype_r;
  logic               has_r;
  logic               last_r;

  // output register refills whenever it is empty or being drained
  assign q_pop     = q_valid && (!valid_r || out_ch.ready);
  assign valid_nxt = q_pop ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r  <= q_item.mask_en ? (q_item.data ^ q_item.key) : q_item.data;
      ftype_r <= q_item.ftype;
      has_r   <= q_item.has_byte;
      last_r  <= q_item.last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.payload_byte  = data_r;
  assign out_ch.frame_type    = ftype_r;
  assign out_ch.has_byte      = has_r;
  assign out_ch.last_of_frame = last_r;

endmodule

// ----- design/websocket_frame_deframer_core.sv -----
// a payload word is written into a queue entry, then into the output register, before it is offered on out_ch
// throughput: one stream word per cycle while out_ch is ready, header words included, set by the parser
//   making one state update per word and the output register refilling every cycle
// reset: synchronous active-low rst_n returns the parser to the first header word
//   and empties the queue and output stage; the mask key needs no clearing
module websocket_frame_deframer_core #(
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);
  import wsd_pkg::*;

  // parser to queue
  logic     push_valid;
  q_item_t  push_item;
  logic     q_full;

  // queue to output stage
  logic     q_valid;
  logic     q_pop;
  q_item_t  q_item;

  // front: walks the frame header, tracks length and key position,
  // emits one word per payload byte or one notice per empty frame
  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_full  (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // short queue so parser and output stage stall independently
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back: unmasks with the key byte and holds the result word
  // until the consumer takes it
  wsd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
